[src/r2n_pkg.sv]
package r2n_pkg;

   // Default line store and frame limits.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Register map.
   localparam int CSR_INDEX_W      = 8;
   localparam int CSR_VALUE_W      = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 8'd1;
   localparam logic [CSR_VALUE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_VALUE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Effective frame sizes go up to 8192, so they need one bit more than a register.
   localparam int SIZE_W = 14;

   // Luma and chroma coefficients, scaled by 256.
   localparam int COEF_Y_R = 77;
   localparam int COEF_Y_G = 150;
   localparam int COEF_Y_B = 29;
   localparam int COEF_U_R = 43;
   localparam int COEF_U_G = 85;
   localparam int COEF_U_B = 128;
   localparam int COEF_V_R = 128;
   localparam int COEF_V_G = 107;
   localparam int COEF_V_B = 21;
   // Offset of 128 in the scaled domain; keeps the chroma accumulators positive.
   localparam int CHROMA_BIAS = 32768;

   localparam int PIX_W  = 8;
   localparam int ACC_W  = 17;
   localparam int SUM_W  = 9;
   localparam int STORE_W = 2 * SUM_W;
   localparam int ROW_NUM_W  = 12;
   localparam int PAIR_NUM_W = 11;

   typedef struct packed {
      logic [PIX_W-1:0] red_left;
      logic [PIX_W-1:0] green_left;
      logic [PIX_W-1:0] blue_left;
      logic [PIX_W-1:0] red_right;
      logic [PIX_W-1:0] green_right;
      logic [PIX_W-1:0] blue_right;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]      luma_left;
      logic [PIX_W-1:0]      luma_right;
      logic [PIX_W-1:0]      chroma_u;
      logic [PIX_W-1:0]      chroma_v;
      logic                  chroma_valid;
      logic [ROW_NUM_W-1:0]  row_number;
      logic [PAIR_NUM_W-1:0] pair_number;
      logic                  frame_end;
   } rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_VALUE_W-1:0] value;
   } csr_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] chroma_u;
      logic [PIX_W-1:0] chroma_v;
   } yuv_type;

endpackage

[src/r2n_channel_if.sv]
interface r2n_channel_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/r2n_pixel_math.sv]
module r2n_pixel_math (
   input  logic [r2n_pkg::PIX_W-1:0] red,
   input  logic [r2n_pkg::PIX_W-1:0] green,
   input  logic [r2n_pkg::PIX_W-1:0] blue,
   output r2n_pkg::yuv_type          yuv
);
   localparam int AW = r2n_pkg::ACC_W;

   logic [AW-1:0] r_ext;
   logic [AW-1:0] g_ext;
   logic [AW-1:0] b_ext;
   logic [AW-1:0] y_acc;
   logic [AW-1:0] u_acc;
   logic [AW-1:0] v_acc;

   assign r_ext = AW'(red);
   assign g_ext = AW'(green);
   assign b_ext = AW'(blue);

   // The luma sum peaks at 65280, so bits 15:8 never need clamping.
   assign y_acc = AW'(r2n_pkg::COEF_Y_R) * r_ext + AW'(r2n_pkg::COEF_Y_G) * g_ext
                + AW'(r2n_pkg::COEF_Y_B) * b_ext;

   // With the bias added the chroma sums stay within 0..65535, so modular
   // arithmetic is exact and bits 15:8 give floor(x / 256) + 128.
   assign u_acc = AW'(r2n_pkg::CHROMA_BIAS) + AW'(r2n_pkg::COEF_U_B) * b_ext
                - AW'(r2n_pkg::COEF_U_R) * r_ext - AW'(r2n_pkg::COEF_U_G) * g_ext;
   assign v_acc = AW'(r2n_pkg::CHROMA_BIAS) + AW'(r2n_pkg::COEF_V_R) * r_ext
                - AW'(r2n_pkg::COEF_V_G) * g_ext - AW'(r2n_pkg::COEF_V_B) * b_ext;

   assign yuv.luma     = y_acc[15:8];
   assign yuv.chroma_u = u_acc[15:8];
   assign yuv.chroma_v = v_acc[15:8];
endmodule

[src/r2n_line_store.sv]
module r2n_line_store #(
   parameter int DEPTH = r2n_pkg::DEF_MAX_WIDTH / 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [r2n_pkg::STORE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [r2n_pkg::STORE_W-1:0] rd_data
);
   logic [r2n_pkg::STORE_W-1:0] mem [DEPTH];
   logic [r2n_pkg::STORE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[src/rgb_to_nv12_converter_top.sv]
// Channel  Port     Direction  Payload
// input    req_bus  sink       r2n_pkg::req_type, one RGB pixel pair
// result   rsp_bus  source     r2n_pkg::rsp_type, luma pair, chroma, position
// config   csr_bus  sink       r2n_pkg::csr_type, register index and value
//
// One pixel pair per clock sustained while results are taken. A result is held
// in the compute stage, then in the output register, and is then offered. The
// rate is set by the line store, which takes one read and one write per cycle;
// a same-cycle hit is bypassed. Reset is synchronous; it clears counters and
// valid flags and loads the size registers with their defaults. The line store
// needs no clearing pass. A stalled result holds the output register, and one
// more pair can still be taken into the compute stage.
module rgb_to_nv12_converter_top #(
   parameter int MAX_WIDTH  = r2n_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = r2n_pkg::DEF_MAX_HEIGHT
) (
   input logic          clock,
   input logic          reset,
   r2n_channel_if.sink  req_bus,
   r2n_channel_if.source rsp_bus,
   r2n_channel_if.sink  csr_bus
);
   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW    = r2n_pkg::SIZE_W;
   localparam int VW    = r2n_pkg::CSR_VALUE_W;
   localparam int SUMW  = r2n_pkg::SUM_W;

   r2n_pkg::req_type req_data;
   r2n_pkg::csr_type csr_data;
   r2n_pkg::rsp_type rsp_data_ff;
   r2n_pkg::rsp_type rsp_data_in;
   logic             rsp_valid_ff;

   assign req_data = req_bus.data;
   assign csr_data = csr_bus.data;

   // Configuration registers.
   logic [VW-1:0] width_ff;
   logic [VW-1:0] height_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= r2n_pkg::FRAME_WIDTH_RESET;
         height_ff <= r2n_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         if (csr_data.index == r2n_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_data.value;
         end else if (csr_data.index == r2n_pkg::CSR_FRAME_HEIGHT) begin
            height_ff <= csr_data.value;
         end
      end
   end

   // Effective sizes: low bit dropped, then held between two and the limit.
   logic [SW-1:0] width_even;
   logic [SW-1:0] height_even;
   logic [SW-1:0] width_eff;
   logic [SW-1:0] rows;
   logic [SW-1:0] pairs;

   assign width_even  = {1'b0, width_ff[VW-1:1], 1'b0};
   assign height_even = {1'b0, height_ff[VW-1:1], 1'b0};

   always_comb begin
      if (width_even < SW'(2)) begin
         width_eff = SW'(2);
      end else if (width_even > SW'(MAX_WIDTH)) begin
         width_eff = SW'(MAX_WIDTH);
      end else begin
         width_eff = width_even;
      end
      if (height_even < SW'(2)) begin
         rows = SW'(2);
      end else if (height_even > SW'(MAX_HEIGHT)) begin
         rows = SW'(MAX_HEIGHT);
      end else begin
         rows = height_even;
      end
   end

   assign pairs = width_eff >> 1;

   // Position counters.
   logic [AW-1:0] pair_ff;
   logic [AW-1:0] pair_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic          row_last;
   logic          frame_last;

   assign row_last   = (SW'(pair_ff) + SW'(1)) >= pairs;
   assign frame_last = (SW'(row_ff) + SW'(1)) >= rows;

   // Handshake and stage control.
   logic s1_valid_ff;
   logic out_en;
   logic accept;

   assign out_en        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || out_en;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      pair_in = pair_ff;
      row_in  = row_ff;
      if (accept) begin
         if (row_last) begin
            pair_in = '0;
            row_in  = frame_last ? '0 : row_ff + RW'(1);
         end else begin
            pair_in = pair_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
         row_ff  <= '0;
      end else begin
         pair_ff <= pair_in;
         row_ff  <= row_in;
      end
   end

   // Color conversion of the incoming pair.
   r2n_pkg::yuv_type yuv_left;
   r2n_pkg::yuv_type yuv_right;

   r2n_pixel_math u_math_left (
      .red   (req_data.red_left),
      .green (req_data.green_left),
      .blue  (req_data.blue_left),
      .yuv   (yuv_left)
   );

   r2n_pixel_math u_math_right (
      .red   (req_data.red_right),
      .green (req_data.green_right),
      .blue  (req_data.blue_right),
      .yuv   (yuv_right)
   );

   // Compute stage registers.
   logic [r2n_pkg::PIX_W-1:0] s1_luma_left_ff;
   logic [r2n_pkg::PIX_W-1:0] s1_luma_right_ff;
   logic [SUMW-1:0]           s1_usum_ff;
   logic [SUMW-1:0]           s1_vsum_ff;
   logic                      s1_odd_ff;
   logic [AW-1:0]             s1_slot_ff;
   logic [RW-1:0]             s1_row_ff;
   logic                      s1_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_left_ff  <= yuv_left.luma;
         s1_luma_right_ff <= yuv_right.luma;
         s1_usum_ff       <= SUMW'(yuv_left.chroma_u) + SUMW'(yuv_right.chroma_u);
         s1_vsum_ff       <= SUMW'(yuv_left.chroma_v) + SUMW'(yuv_right.chroma_v);
         s1_odd_ff        <= row_ff[0];
         s1_slot_ff       <= pair_ff;
         s1_row_ff        <= row_ff;
         s1_fend_ff       <= row_last && frame_last;
      end
   end

   // Line store: read at the input transfer, written when an even-row pair
   // leaves the compute stage.
   logic                        store_we;
   logic [r2n_pkg::STORE_W-1:0] store_wdata;
   logic [r2n_pkg::STORE_W-1:0] store_rdata;
   logic                        bypass_ff;
   logic [r2n_pkg::STORE_W-1:0] bypass_data_ff;
   logic [r2n_pkg::STORE_W-1:0] stored_sums;

   assign store_we    = s1_valid_ff && out_en && !s1_odd_ff;
   assign store_wdata = {s1_usum_ff, s1_vsum_ff};

   r2n_line_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (s1_slot_ff),
      .wr_data (store_wdata),
      .rd_en   (accept),
      .rd_addr (pair_ff),
      .rd_data (store_rdata)
   );

   // With a one-pair-wide frame the even-row write and the odd-row read of
   // the same slot meet in one cycle; the write data is taken instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         bypass_ff      <= store_we && (s1_slot_ff == pair_ff);
         bypass_data_ff <= store_wdata;
      end
   end

   assign stored_sums = bypass_ff ? bypass_data_ff : store_rdata;

   // Output stage.
   logic [SUMW:0] u_total;
   logic [SUMW:0] v_total;

   assign u_total = (SUMW+1)'(stored_sums[2*SUMW-1:SUMW]) + (SUMW+1)'(s1_usum_ff);
   assign v_total = (SUMW+1)'(stored_sums[SUMW-1:0]) + (SUMW+1)'(s1_vsum_ff);

   always_comb begin
      rsp_data_in.luma_left    = s1_luma_left_ff;
      rsp_data_in.luma_right   = s1_luma_right_ff;
      rsp_data_in.chroma_u     = s1_odd_ff ? u_total[SUMW:2] : '0;
      rsp_data_in.chroma_v     = s1_odd_ff ? v_total[SUMW:2] : '0;
      rsp_data_in.chroma_valid = s1_odd_ff;
      rsp_data_in.row_number   = r2n_pkg::ROW_NUM_W'(s1_row_ff);
      rsp_data_in.pair_number  = r2n_pkg::PAIR_NUM_W'(s1_slot_ff);
      rsp_data_in.frame_end    = s1_fend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // Checks.
   assert property (@(posedge clock) disable iff (reset)
      accept && row_last && frame_last |=> pair_ff == '0 && row_ff == '0)
      else $error("counters did not wrap at the end of the frame");

   assert property (@(posedge clock) disable iff (reset)
      SW'(pair_ff) < SW'(DEPTH) || DEPTH == 0)
      else $error("pair counter beyond the line store depth");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_bus.ready |=> s1_valid_ff && $stable(s1_slot_ff))
      else $error("compute stage lost a pair while the output was stalled");
endmodule

[tb/rgb_to_nv12_converter_top_tb.sv]
module rgb_to_nv12_converter_top_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int STORE_SLOTS = r2n_pkg::DEF_MAX_WIDTH / 2;
   localparam logic [r2n_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 8'd7;

   // Predicts the luma pair, the subsampled chroma and the frame position of every
   // accepted pixel pair, and checks the converter's results against it in order.
   class nv12_scoreboard;
      logic [r2n_pkg::CSR_VALUE_W-1:0] width_reg;
      logic [r2n_pkg::CSR_VALUE_W-1:0] height_reg;
      int unsigned pair_count;
      int unsigned row_count;
      logic [r2n_pkg::SUM_W-1:0] u_line[STORE_SLOTS];
      logic [r2n_pkg::SUM_W-1:0] v_line[STORE_SLOTS];
      r2n_pkg::rsp_type pending[$];
      int unsigned mismatches;
      int unsigned pairs_seen;
      int unsigned chroma_blocks;
      int unsigned frame_ends;
      int unsigned size_writes;

      function new();
         width_reg     = r2n_pkg::FRAME_WIDTH_RESET;
         height_reg    = r2n_pkg::FRAME_HEIGHT_RESET;
         pair_count    = 0;
         row_count     = 0;
         mismatches    = 0;
         pairs_seen    = 0;
         chroma_blocks = 0;
         frame_ends    = 0;
         size_writes   = 0;
      endfunction

      function void write_register(logic [r2n_pkg::CSR_INDEX_W-1:0] reg_index,
                                   logic [r2n_pkg::CSR_VALUE_W-1:0] reg_value);
         if (reg_index == r2n_pkg::CSR_FRAME_WIDTH) begin
            width_reg = reg_value;
            size_writes++;
         end else if (reg_index == r2n_pkg::CSR_FRAME_HEIGHT) begin
            height_reg = reg_value;
            size_writes++;
         end
      endfunction

      // Odd sizes lose their low bit, zero becomes two, and the maximum caps the rest.
      function int unsigned usable_size(logic [r2n_pkg::CSR_VALUE_W-1:0] reg_value,
                                        int unsigned limit);
         int unsigned s;
         s = reg_value & 13'h1FFE;
         if (s < 2) s = 2;
         if (s > limit) s = limit;
         return s;
      endfunction

      function logic [r2n_pkg::PIX_W-1:0] pixel_luma(logic [r2n_pkg::PIX_W-1:0] r,
                                                     logic [r2n_pkg::PIX_W-1:0] g,
                                                     logic [r2n_pkg::PIX_W-1:0] b);
         int unsigned y;
         y = (r2n_pkg::COEF_Y_R * int'(r) + r2n_pkg::COEF_Y_G * int'(g)
              + r2n_pkg::COEF_Y_B * int'(b)) >> 8;
         if (y > 255) y = 255;
         return y[7:0];
      endfunction

      function logic [r2n_pkg::PIX_W-1:0] pixel_u(logic [r2n_pkg::PIX_W-1:0] r,
                                                  logic [r2n_pkg::PIX_W-1:0] g,
                                                  logic [r2n_pkg::PIX_W-1:0] b);
         int x;
         x = -r2n_pkg::COEF_U_R * int'(r) - r2n_pkg::COEF_U_G * int'(g)
             + r2n_pkg::COEF_U_B * int'(b);
         return 8'((x + r2n_pkg::CHROMA_BIAS) >>> 8);
      endfunction

      function logic [r2n_pkg::PIX_W-1:0] pixel_v(logic [r2n_pkg::PIX_W-1:0] r,
                                                  logic [r2n_pkg::PIX_W-1:0] g,
                                                  logic [r2n_pkg::PIX_W-1:0] b);
         int x;
         x = r2n_pkg::COEF_V_R * int'(r) - r2n_pkg::COEF_V_G * int'(g)
             - r2n_pkg::COEF_V_B * int'(b);
         return 8'((x + r2n_pkg::CHROMA_BIAS) >>> 8);
      endfunction

      function void note_pair(r2n_pkg::req_type px);
         r2n_pkg::rsp_type want;
         int unsigned pairs;
         int unsigned rows;
         int unsigned slot;
         int unsigned cu;
         int unsigned cv;
         logic [r2n_pkg::SUM_W-1:0] u_sum;
         logic [r2n_pkg::SUM_W-1:0] v_sum;
         pairs = usable_size(width_reg, r2n_pkg::DEF_MAX_WIDTH) >> 1;
         rows  = usable_size(height_reg, r2n_pkg::DEF_MAX_HEIGHT);
         slot  = pair_count % STORE_SLOTS;
         u_sum = pixel_u(px.red_left, px.green_left, px.blue_left)
               + pixel_u(px.red_right, px.green_right, px.blue_right);
         v_sum = pixel_v(px.red_left, px.green_left, px.blue_left)
               + pixel_v(px.red_right, px.green_right, px.blue_right);
         want = '0;
         want.luma_left  = pixel_luma(px.red_left, px.green_left, px.blue_left);
         want.luma_right = pixel_luma(px.red_right, px.green_right, px.blue_right);
         if (row_count[0] == 1'b0) begin
            u_line[slot] = u_sum;
            v_line[slot] = v_sum;
         end else begin
            cu = (int'(u_line[slot]) + int'(u_sum)) >> 2;
            cv = (int'(v_line[slot]) + int'(v_sum)) >> 2;
            if (cu > 255) cu = 255;
            if (cv > 255) cv = 255;
            want.chroma_u     = cu[7:0];
            want.chroma_v     = cv[7:0];
            want.chroma_valid = 1'b1;
         end
         want.row_number  = row_count[r2n_pkg::ROW_NUM_W-1:0];
         want.pair_number = pair_count[r2n_pkg::PAIR_NUM_W-1:0];
         // A counter at or past the last position wraps here, even after a size change.
         if (pair_count + 1 >= pairs) begin
            pair_count = 0;
            if (row_count + 1 >= rows) begin
               row_count = 0;
               want.frame_end = 1'b1;
            end else begin
               row_count++;
            end
         end else begin
            pair_count++;
         end
         pending.push_back(want);
         pairs_seen++;
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_pair(r2n_pkg::rsp_type got);
         r2n_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            $error("result transfer with no pixel pair outstanding: %p", got);
            return;
         end
         want = pending.pop_front();
         compare("luma_left", want.luma_left, got.luma_left);
         compare("luma_right", want.luma_right, got.luma_right);
         compare("chroma_u", want.chroma_u, got.chroma_u);
         compare("chroma_v", want.chroma_v, got.chroma_v);
         compare("chroma_valid", want.chroma_valid, got.chroma_valid);
         compare("row_number", want.row_number, got.row_number);
         compare("pair_number", want.pair_number, got.pair_number);
         compare("frame_end", want.frame_end, got.frame_end);
         if (want.chroma_valid) chroma_blocks++;
         if (want.frame_end) frame_ends++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   r2n_channel_if #(.payload_type(r2n_pkg::req_type)) req_bus ();
   r2n_channel_if #(.payload_type(r2n_pkg::rsp_type)) rsp_bus ();
   r2n_channel_if #(.payload_type(r2n_pkg::csr_type)) csr_bus ();

   rgb_to_nv12_converter_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   nv12_scoreboard sb = new();
   int unsigned cycles_run = 0;
   int unsigned burst_left = 0;
   int unsigned long_stalls = 0;
   bit hold_off_armed = 1'b0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // All handshake signals are sampled here at the edge, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_register(csr_bus.data.index, csr_bus.data.value);
         if (req_bus.valid && req_bus.ready) sb.note_pair(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_pair(rsp_bus.data);
      end
   end

   initial begin : result_receiver
      int mode;
      int span;
      int k;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_off_armed) begin
            // A long hold-off lets the converter fill up and push back on its input.
            hold_off_armed = 1'b0;
            long_stalls++;
            for (k = 0; k < 120; k++) begin
               @(posedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (k = 0; k < span; k++) begin
               @(posedge clock);
               case (mode)
                  0: begin
                     rsp_bus.ready <= 1'b1;
                  end
                  1: begin
                     rsp_bus.ready <= 1'($urandom_range(0, 1));
                  end
                  2: begin
                     rsp_bus.ready <= (k % 4) != 3;
                  end
                  default: begin
                     rsp_bus.ready <= $urandom_range(0, 3) == 0;
                  end
               endcase
            end
         end
      end
   end

   function automatic r2n_pkg::req_type make_pair(logic [7:0] rl, logic [7:0] gl,
                                                  logic [7:0] bl, logic [7:0] rr,
                                                  logic [7:0] gr, logic [7:0] br);
      r2n_pkg::req_type px;
      px.red_left    = rl;
      px.green_left  = gl;
      px.blue_left   = bl;
      px.red_right   = rr;
      px.green_right = gr;
      px.blue_right  = br;
      return px;
   endfunction

   // One channel in five is pinned to black or full scale to hit the clamps often.
   function automatic logic [7:0] random_channel();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic r2n_pkg::req_type random_pair();
      return make_pair(random_channel(), random_channel(), random_channel(),
                       random_channel(), random_channel(), random_channel());
   endfunction

   task automatic send_pair(input r2n_pkg::req_type px);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 160);
            gap = 1;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 7);
         end
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= px;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // Stops the sender and waits until every outstanding pixel pair has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [r2n_pkg::CSR_INDEX_W-1:0] reg_index,
                            input logic [r2n_pkg::CSR_VALUE_W-1:0] reg_value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= {reg_index, reg_value};
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sizes only change on an even row, so every odd row reads line store slots
   // that the even row above it has written. An odd row is left by narrowing
   // the frame to one pair, which wraps the row on the next pair.
   task automatic leave_odd_row();
      if (sb.row_count[0]) begin
         write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd2);
         send_pair(random_pair());
         settle();
      end
   endtask

   initial begin : stimulus
      int random_pairs;
      int span;
      bit first_phase;
      logic [r2n_pkg::CSR_VALUE_W-1:0] size_pick;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two 4x2 frames of extreme colors: black and white, and the corners of U and V.
      write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd4);
      write_csr(r2n_pkg::CSR_FRAME_HEIGHT, 13'd2);
      send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
      send_pair(make_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
      send_pair(make_pair(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
      send_pair(make_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
      send_pair(make_pair(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00));
      send_pair(make_pair(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF));
      send_pair(make_pair(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00));
      send_pair(make_pair(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF));

      // Odd sizes round down to 6x2.
      settle();
      write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd7);
      write_csr(r2n_pkg::CSR_FRAME_HEIGHT, 13'd3);
      repeat (6) send_pair(random_pair());

      // Sizes below two are raised to two; an unmapped index must change nothing.
      settle();
      write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd0);
      write_csr(r2n_pkg::CSR_FRAME_HEIGHT, 13'd1);
      write_csr(CSR_UNMAPPED, 13'h1FFF);
      repeat (4) send_pair(random_pair());

      // Stop a 20x6 frame in its third row, then shrink both sizes so that the
      // pair and row counters are past the new ends and wrap on the next pair.
      settle();
      write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd20);
      write_csr(r2n_pkg::CSR_FRAME_HEIGHT, 13'd6);
      repeat (25) send_pair(random_pair());
      settle();
      write_csr(r2n_pkg::CSR_FRAME_WIDTH, 13'd4);
      write_csr(r2n_pkg::CSR_FRAME_HEIGHT, 13'd2);
      repeat (5) send_pair(random_pair());

      random_pairs = 0;
      first_phase = 1'b1;
      while (random_pairs < 1320) begin
         settle();
         leave_odd_row();
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 5))
                  0: size_pick = 13'd1;
                  1: size_pick = 13'd2;
                  2: size_pick = 13'd4096;
                  3: size_pick = 13'd4097;
                  4: size_pick = 13'h1FFE;
                  default: size_pick = 13'h1FFF;
               endcase
            end
            1: begin
               size_pick = 13'($urandom_range(41, 400));
            end
            default: begin
               size_pick = 13'($urandom_range(0, 40));
            end
         endcase
         write_csr(r2n_pkg::CSR_FRAME_WIDTH, size_pick);
         case ($urandom_range(0, 7))
            0: size_pick = 13'd4096;
            1: size_pick = 13'h1FFF;
            2: size_pick = 13'd2;
            default: size_pick = 13'($urandom_range(0, 10));
         endcase
         write_csr(r2n_pkg::CSR_FRAME_HEIGHT, size_pick);
         if ($urandom_range(0, 3) == 0)
            write_csr(8'($urandom_range(2, 255)), 13'($urandom_range(0, 8191)));
         span = first_phase ? 400 : $urandom_range(20, 150);
         if (first_phase) hold_off_armed = 1'b1;
         first_phase = 1'b0;
         repeat (span) send_pair(random_pair());
         random_pairs += span;
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Converted %0d pixel pairs: %0d chroma blocks, %0d frame ends,",
               sb.pairs_seen, sb.chroma_blocks, sb.frame_ends);
      $display("%0d size register writes and %0d long output stalls.",
               sb.size_writes, long_stalls);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
